FILE: hw/rtl/ogog_pkg.sv
// Shared constants, types and a helper function for the oriented grid offset generator.
package ogog_pkg;

  localparam int MAX_EXTENT = 64;
  localparam int COORD_W    = $clog2(MAX_EXTENT);
  localparam int N_W        = COORD_W + 1;
  localparam int P_W        = 2 * N_W;
  localparam int EXT_REG_W  = 7;
  localparam int ORDER_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int IDX_W      = 18;
  localparam int SUM_W      = P_W + COORD_W + 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT_X   = 3'd0,
    REG_EXTENT_Y   = 3'd1,
    REG_EXTENT_Z   = 3'd2,
    REG_FORWARD_X  = 3'd3,
    REG_FORWARD_Y  = 3'd4,
    REG_FORWARD_Z  = 3'd5,
    REG_AXIS_ORDER = 3'd6
  } cfg_reg_t;

  typedef enum logic [ORDER_W-1:0] {
    ORDER_012 = 3'd0,
    ORDER_120 = 3'd1,
    ORDER_201 = 3'd2,
    ORDER_021 = 3'd3,
    ORDER_210 = 3'd4,
    ORDER_102 = 3'd5
  } axis_order_t;

  // Effective grid shape, with the pairwise extent products used as strides.
  typedef struct packed {
    logic [N_W-1:0]     n1;
    logic [N_W-1:0]     n2;
    logic [N_W-1:0]     n3;
    logic [2:0]         fwd;
    logic [ORDER_W-1:0] order;
    logic [P_W-1:0]     n12;
    logic [P_W-1:0]     n13;
    logic [P_W-1:0]     n23;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } point_t;

  // A zero extent acts as one, and large extents saturate.
  function automatic logic [N_W-1:0] eff_extent(input logic [EXT_REG_W-1:0] e);
    logic [N_W-1:0] r;
    if (e == '0) begin
      r = N_W'(1);
    end else if (int'(e) > MAX_EXTENT) begin
      r = N_W'(MAX_EXTENT);
    end else begin
      r = N_W'(e);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ogog_cfg.sv
// Configuration registers, effective extents and registered extent products.
module ogog_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ogog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ogog_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ogog_pkg::cfg_t                    cfg
);

  logic [ogog_pkg::EXT_REG_W-1:0] extent_x;
  logic [ogog_pkg::EXT_REG_W-1:0] extent_y;
  logic [ogog_pkg::EXT_REG_W-1:0] extent_z;
  logic                           forward_x;
  logic                           forward_y;
  logic                           forward_z;
  logic [ogog_pkg::ORDER_W-1:0]   axis_order;
  logic [ogog_pkg::N_W-1:0]       n1;
  logic [ogog_pkg::N_W-1:0]       n2;
  logic [ogog_pkg::N_W-1:0]       n3;
  logic [ogog_pkg::P_W-1:0]       n12;
  logic [ogog_pkg::P_W-1:0]       n13;
  logic [ogog_pkg::P_W-1:0]       n23;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_x   <= ogog_pkg::EXT_REG_W'(1);
      extent_y   <= ogog_pkg::EXT_REG_W'(1);
      extent_z   <= ogog_pkg::EXT_REG_W'(1);
      forward_x  <= 1'b1;
      forward_y  <= 1'b1;
      forward_z  <= 1'b1;
      axis_order <= ogog_pkg::ORDER_012;
    end else if (cfg_we) begin
      unique case (ogog_pkg::cfg_reg_t'(cfg_index))
        ogog_pkg::REG_EXTENT_X:   extent_x   <= cfg_data[ogog_pkg::EXT_REG_W-1:0];
        ogog_pkg::REG_EXTENT_Y:   extent_y   <= cfg_data[ogog_pkg::EXT_REG_W-1:0];
        ogog_pkg::REG_EXTENT_Z:   extent_z   <= cfg_data[ogog_pkg::EXT_REG_W-1:0];
        ogog_pkg::REG_FORWARD_X:  forward_x  <= cfg_data[0];
        ogog_pkg::REG_FORWARD_Y:  forward_y  <= cfg_data[0];
        ogog_pkg::REG_FORWARD_Z:  forward_z  <= cfg_data[0];
        ogog_pkg::REG_AXIS_ORDER: axis_order <= cfg_data[ogog_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  assign n1 = ogog_pkg::eff_extent(extent_x);
  assign n2 = ogog_pkg::eff_extent(extent_y);
  assign n3 = ogog_pkg::eff_extent(extent_z);

  // Products settle the cycle after a write, before any item may follow it.
  always_ff @(posedge clk) begin
    if (rst) begin
      n12 <= ogog_pkg::P_W'(1);
      n13 <= ogog_pkg::P_W'(1);
      n23 <= ogog_pkg::P_W'(1);
    end else begin
      n12 <= ogog_pkg::P_W'(n1) * ogog_pkg::P_W'(n2);
      n13 <= ogog_pkg::P_W'(n1) * ogog_pkg::P_W'(n3);
      n23 <= ogog_pkg::P_W'(n2) * ogog_pkg::P_W'(n3);
    end
  end

  always_comb begin
    cfg.n1    = n1;
    cfg.n2    = n2;
    cfg.n3    = n3;
    cfg.fwd   = {forward_z, forward_y, forward_x};
    cfg.order = axis_order;
    cfg.n12   = n12;
    cfg.n13   = n13;
    cfg.n23   = n23;
  end

endmodule

FILE: hw/rtl/ogog_walk.sv
// Coordinate counters: picks the point for each accepted item and registers it.
module ogog_walk (
  input  logic                 clk,
  input  logic                 rst,
  input  ogog_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  output logic                 pt_valid,
  input  logic                 pt_ready,
  output ogog_pkg::point_t     pt
);

  logic [ogog_pkg::COORD_W-1:0] coord_x;
  logic [ogog_pkg::COORD_W-1:0] coord_y;
  logic [ogog_pkg::COORD_W-1:0] coord_z;
  logic [ogog_pkg::COORD_W-1:0] coord_x_next;
  logic [ogog_pkg::COORD_W-1:0] coord_y_next;
  logic [ogog_pkg::COORD_W-1:0] coord_z_next;
  logic                         wrap;
  logic                         accept;
  ogog_pkg::point_t             cur;
  logic [ogog_pkg::N_W-1:0]     inc_x;
  logic [ogog_pkg::N_W-1:0]     inc_y;
  logic [ogog_pkg::N_W-1:0]     inc_z;

  assign in_ready = !pt_valid || pt_ready;
  assign accept   = in_valid && in_ready;

  // The restart input, or a coordinate left out of range by shrunk extents, restarts the table.
  assign wrap = restart
             || ({1'b0, coord_x} >= cfg.n1)
             || ({1'b0, coord_y} >= cfg.n2)
             || ({1'b0, coord_z} >= cfg.n3);

  always_comb begin
    cur.x    = wrap ? '0 : coord_x;
    cur.y    = wrap ? '0 : coord_y;
    cur.z    = wrap ? '0 : coord_z;
    cur.last = ({1'b0, cur.x} == cfg.n1 - 1'b1)
            && ({1'b0, cur.y} == cfg.n2 - 1'b1)
            && ({1'b0, cur.z} == cfg.n3 - 1'b1);

    inc_x = {1'b0, cur.x} + 1'b1;
    inc_y = {1'b0, cur.y} + 1'b1;
    inc_z = {1'b0, cur.z} + 1'b1;
    coord_x_next = cur.x;
    coord_y_next = cur.y;
    coord_z_next = cur.z;
    if (inc_x < cfg.n1) begin
      coord_x_next = inc_x[ogog_pkg::COORD_W-1:0];
    end else begin
      coord_x_next = '0;
      if (inc_y < cfg.n2) begin
        coord_y_next = inc_y[ogog_pkg::COORD_W-1:0];
      end else begin
        coord_y_next = '0;
        coord_z_next = (inc_z < cfg.n3) ? inc_z[ogog_pkg::COORD_W-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_x  <= '0;
      coord_y  <= '0;
      coord_z  <= '0;
      pt_valid <= 1'b0;
    end else if (accept) begin
      coord_x  <= coord_x_next;
      coord_y  <= coord_y_next;
      coord_z  <= coord_z_next;
      pt_valid <= 1'b1;
    end else if (pt_ready) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt <= cur;
    end
  end

endmodule

FILE: hw/rtl/ogog_offset.sv
// Index and oriented offset of a registered point, held in the output register.
module ogog_offset (
  input  logic                            clk,
  input  logic                            rst,
  input  ogog_pkg::cfg_t                  cfg,
  input  logic                            pt_valid,
  output logic                            pt_ready,
  input  ogog_pkg::point_t                pt,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ogog_pkg::IDX_W-1:0]      out_index,
  output logic [ogog_pkg::IDX_W-1:0]      out_offset,
  output logic                            out_last
);

  logic [ogog_pkg::COORD_W-1:0] a1;
  logic [ogog_pkg::COORD_W-1:0] a2;
  logic [ogog_pkg::COORD_W-1:0] a3;
  logic [ogog_pkg::COORD_W-1:0] fast;
  logic [ogog_pkg::COORD_W-1:0] mid;
  logic [ogog_pkg::COORD_W-1:0] slow;
  logic [ogog_pkg::N_W-1:0]     mid_stride;
  logic [ogog_pkg::P_W-1:0]     slow_stride;
  logic [ogog_pkg::SUM_W-1:0]   index_sum;
  logic [ogog_pkg::SUM_W-1:0]   offset_sum;

  assign pt_ready = !out_valid || out_ready;

  always_comb begin
    a1 = cfg.fwd[0] ? pt.x
                    : ogog_pkg::COORD_W'(cfg.n1 - 1'b1 - {1'b0, pt.x});
    a2 = cfg.fwd[1] ? pt.y
                    : ogog_pkg::COORD_W'(cfg.n2 - 1'b1 - {1'b0, pt.y});
    a3 = cfg.fwd[2] ? pt.z
                    : ogog_pkg::COORD_W'(cfg.n3 - 1'b1 - {1'b0, pt.z});

    // Orders six and seven act as the last defined order.
    unique case (ogog_pkg::axis_order_t'(cfg.order))
      ogog_pkg::ORDER_012: begin
        fast = a1; mid = a2; slow = a3; mid_stride = cfg.n1; slow_stride = cfg.n12;
      end
      ogog_pkg::ORDER_120: begin
        fast = a3; mid = a1; slow = a2; mid_stride = cfg.n3; slow_stride = cfg.n13;
      end
      ogog_pkg::ORDER_201: begin
        fast = a2; mid = a3; slow = a1; mid_stride = cfg.n2; slow_stride = cfg.n23;
      end
      ogog_pkg::ORDER_021: begin
        fast = a1; mid = a3; slow = a2; mid_stride = cfg.n1; slow_stride = cfg.n13;
      end
      ogog_pkg::ORDER_210: begin
        fast = a3; mid = a2; slow = a1; mid_stride = cfg.n3; slow_stride = cfg.n23;
      end
      default: begin
        fast = a2; mid = a1; slow = a3; mid_stride = cfg.n2; slow_stride = cfg.n12;
      end
    endcase

    index_sum  = ogog_pkg::SUM_W'(pt.x)
               + ogog_pkg::SUM_W'(cfg.n1) * ogog_pkg::SUM_W'(pt.y)
               + ogog_pkg::SUM_W'(cfg.n12) * ogog_pkg::SUM_W'(pt.z);
    offset_sum = ogog_pkg::SUM_W'(fast)
               + ogog_pkg::SUM_W'(mid_stride) * ogog_pkg::SUM_W'(mid)
               + ogog_pkg::SUM_W'(slow_stride) * ogog_pkg::SUM_W'(slow);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pt_ready) begin
      out_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_valid && pt_ready) begin
      out_index  <= index_sum[ogog_pkg::IDX_W-1:0];
      out_offset <= offset_sum[ogog_pkg::IDX_W-1:0];
      out_last   <= pt.last;
    end
  end

endmodule

FILE: hw/rtl/oriented_grid_offset_generator.sv
// Top level of the oriented grid offset generator: address table for a 3D transpose/flip.
//
//   channel   | direction | handshake         | contents
//   ----------+-----------+-------------------+--------------------------------------
//   s_        | in        | s_tvalid/s_tready | s_tdata[0] restart
//   m_        | out       | m_tvalid/m_tready | m_tdata table_index, oriented_offset;
//             |           |                   | m_tlast last
//   cfg_      | in        | cfg_we            | cfg_index selects, cfg_data writes
//
// One item per cycle is accepted unless both full stages stall. The coordinate counters
// step once per accepted item into the point register; index and offset are two stride
// multiplies and adds on the registered point, feeding the output register.
// A stalled output holds both stages and drops s_tready only when both are full.
// Synchronous reset clears the counters and stage valids and resets the configuration.
module oriented_grid_offset_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ogog_pkg::IN_DATA_W-1:0]     s_tdata,   // [0] restart, [7:1] zero
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ogog_pkg::OUT_DATA_W-1:0]    m_tdata,   // [17:0] table_index,
                                                        // [35:18] oriented_offset,
                                                        // [39:36] zero
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [ogog_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ogog_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ogog_pkg::cfg_t                cfg;
  ogog_pkg::point_t              pt;
  logic                          pt_valid;
  logic                          pt_ready;
  logic [ogog_pkg::IDX_W-1:0]    out_index;
  logic [ogog_pkg::IDX_W-1:0]    out_offset;

  ogog_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ogog_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .restart  (s_tdata[0]),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .pt       (pt)
  );

  ogog_offset u_offset (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt         (pt),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_index  (out_index),
    .out_offset (out_offset),
    .out_last   (m_tlast)
  );

  assign m_tdata = {(ogog_pkg::OUT_DATA_W - 2 * ogog_pkg::IDX_W)'(0), out_offset, out_index};

endmodule

FILE: hw/rtl/ogog_checker.sv
// Port-level checker for the oriented grid offset generator, bound to the top level.
module ogog_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [ogog_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               m_tlast
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Items accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed or dropped");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 2'd0)
    else $error("result shown without an accepted item");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 && !m_tready |-> !s_tready)
    else $error("input accepted with both stages full");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ogog_pkg::OUT_DATA_W-1:2*ogog_pkg::IDX_W] == '0)
    else $error("result padding bits not zero");

endmodule

bind oriented_grid_offset_generator ogog_checker u_ogog_checker (.*);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the oriented grid offset generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int PIPE_LATENCY = 2;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_STRETCH = 80;
  localparam logic [ogog_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [ogog_pkg::IDX_W-1:0] tab_index;
    logic [ogog_pkg::IDX_W-1:0] tab_offset;
    logic                       tab_last;
  } table_entry_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ogog_pkg::IN_DATA_W-1:0]  s_tdata = '0;    // [0] restart, [7:1] zero
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ogog_pkg::OUT_DATA_W-1:0] m_tdata;   // [17:0] table_index, [35:18] oriented_offset
  logic                            m_tlast;
  logic                            cfg_we = 1'b0;
  logic [ogog_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ogog_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the registers and of the grid walk.
  logic [ogog_pkg::EXT_REG_W-1:0] ext_reg [3];
  logic                           fwd_reg [3];
  logic [ogog_pkg::ORDER_W-1:0]   order_reg;
  int unsigned                    walk_x, walk_y, walk_z;

  table_entry_t table_expect [$];
  table_entry_t want_entry, seen_entry;
  int           fail_count   = 0;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  int           hold_cycles  = 0;
  int           quiet_cycles = 0;

  oriented_grid_offset_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic int unsigned clamp_extent(input logic [ogog_pkg::EXT_REG_W-1:0] e);
    int unsigned n;
    n = e;
    if (n == 0) begin
      n = 1;
    end else if (n > ogog_pkg::MAX_EXTENT) begin
      n = ogog_pkg::MAX_EXTENT;
    end
    return n;
  endfunction

  function automatic int unsigned calc_offset(input int unsigned x, y, z, n1, n2, n3);
    int unsigned a1, a2, a3, r;
    a1 = fwd_reg[0] ? x : n1 - 1 - x;
    a2 = fwd_reg[1] ? y : n2 - 1 - y;
    a3 = fwd_reg[2] ? z : n3 - 1 - z;
    case (order_reg)
      ogog_pkg::ORDER_012: r = a1 + n1 * a2 + n1 * n2 * a3;
      ogog_pkg::ORDER_120: r = a3 + n3 * a1 + n3 * n1 * a2;
      ogog_pkg::ORDER_201: r = a2 + n2 * a3 + n2 * n3 * a1;
      ogog_pkg::ORDER_021: r = a1 + n1 * a3 + n1 * n3 * a2;
      ogog_pkg::ORDER_210: r = a3 + n3 * a2 + n3 * n2 * a1;
      default:             r = a2 + n2 * a1 + n2 * n1 * a3;
    endcase
    return r;
  endfunction

  // Emits the table entry for one accepted item and moves the walk on by one point.
  task automatic predict_entry(input logic restart);
    int unsigned  n1, n2, n3;
    table_entry_t e;
    n1 = clamp_extent(ext_reg[0]);
    n2 = clamp_extent(ext_reg[1]);
    n3 = clamp_extent(ext_reg[2]);
    // A shrunk extent that strands the walk outside the grid restarts the table.
    if (restart || walk_x >= n1 || walk_y >= n2 || walk_z >= n3) begin
      walk_x = 0;
      walk_y = 0;
      walk_z = 0;
    end
    e.tab_index  = ogog_pkg::IDX_W'(walk_x + n1 * (walk_y + n2 * walk_z));
    e.tab_offset = ogog_pkg::IDX_W'(calc_offset(walk_x, walk_y, walk_z, n1, n2, n3));
    e.tab_last   = (walk_x == n1 - 1) && (walk_y == n2 - 1) && (walk_z == n3 - 1);
    table_expect.push_back(e);
    walk_x++;
    if (walk_x >= n1) begin
      walk_x = 0;
      walk_y++;
      if (walk_y >= n2) begin
        walk_y = 0;
        walk_z++;
        if (walk_z >= n3) begin
          walk_z = 0;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [ogog_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ogog_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ogog_pkg::REG_EXTENT_X:   ext_reg[0] = val;
      ogog_pkg::REG_EXTENT_Y:   ext_reg[1] = val;
      ogog_pkg::REG_EXTENT_Z:   ext_reg[2] = val;
      ogog_pkg::REG_FORWARD_X:  fwd_reg[0] = val[0];
      ogog_pkg::REG_FORWARD_Y:  fwd_reg[1] = val[0];
      ogog_pkg::REG_FORWARD_Z:  fwd_reg[2] = val[0];
      ogog_pkg::REG_AXIS_ORDER: order_reg  = val[ogog_pkg::ORDER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_shape(input logic [ogog_pkg::CFG_DATA_W-1:0] nx, ny, nz,
                           input logic fx, fy, fz,
                           input logic [ogog_pkg::ORDER_W-1:0] order);
    write_reg(ogog_pkg::REG_EXTENT_X, nx);
    write_reg(ogog_pkg::REG_EXTENT_Y, ny);
    write_reg(ogog_pkg::REG_EXTENT_Z, nz);
    write_reg(ogog_pkg::REG_FORWARD_X, {6'd0, fx});
    write_reg(ogog_pkg::REG_FORWARD_Y, {6'd0, fy});
    write_reg(ogog_pkg::REG_FORWARD_Z, {6'd0, fz});
    write_reg(ogog_pkg::REG_AXIS_ORDER, {4'd0, order});
  endtask

  // Called and left at a falling edge.
  task automatic send_item(input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(ogog_pkg::IN_DATA_W-1){1'b0}}, restart};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_entry(restart);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (table_expect.size() > 0) @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_item(1'b0);
    send_item(1'b1);
    wait_all_results();
  endtask

  task automatic test_extreme_shapes();
    // All axes reversed on the largest grid puts the top offset at index zero.
    set_shape(7'd64, 7'd64, 7'd64, 1'b0, 1'b0, 1'b0, ogog_pkg::ORDER_012);
    send_item(1'b1);
    send_item(1'b0);
    wait_all_results();
    write_reg(ogog_pkg::REG_EXTENT_X, 7'd127);
    send_item(1'b1);
    wait_all_results();
    set_shape(7'd0, 7'd0, 7'd0, 1'b1, 1'b1, 1'b1, ogog_pkg::ORDER_012);
    send_item(1'b0);
    wait_all_results();
    write_reg(REG_SPARE, 7'h7F);
    send_item(1'b0);
    wait_all_results();
  endtask

  task automatic test_axis_orders();
    set_shape(7'd2, 7'd3, 7'd2, 1'b0, 1'b1, 1'b0, ogog_pkg::ORDER_012);
    for (int o = 0; o < 8; o++) begin
      write_reg(ogog_pkg::REG_AXIS_ORDER, ogog_pkg::CFG_DATA_W'(o));
      send_item(o == 0);
      send_item(1'b0);
      wait_all_results();
    end
  endtask

  task automatic test_shrunk_extents();
    set_shape(7'd3, 7'd1, 7'd1, 1'b1, 1'b1, 1'b1, ogog_pkg::ORDER_012);
    send_item(1'b1);
    send_item(1'b0);
    wait_all_results();
    // The walk now sits at x = 2, which the smaller extent no longer holds.
    write_reg(ogog_pkg::REG_EXTENT_X, 7'd2);
    send_item(1'b0);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    set_shape(7'd4, 7'd3, 7'd2, 1'b1, 1'b0, 1'b1, ogog_pkg::ORDER_201);
    hold_cycles = HOLD_STRETCH;
    repeat (40) send_item(1'b0);
    wait_all_results();
  endtask

  task automatic randomize_registers();
    int r;
    for (int i = ogog_pkg::REG_EXTENT_X; i <= ogog_pkg::REG_EXTENT_Z; i++) begin
      if ($urandom_range(99) < 75) begin
        r = $urandom_range(99);
        if (r < 6) begin
          write_reg(ogog_pkg::CFG_IDX_W'(i), 7'd0);
        end else if (r < 12) begin
          write_reg(ogog_pkg::CFG_IDX_W'(i),
                    ogog_pkg::CFG_DATA_W'($urandom_range(127, 64)));
        end else begin
          write_reg(ogog_pkg::CFG_IDX_W'(i), ogog_pkg::CFG_DATA_W'($urandom_range(6, 1)));
        end
      end
    end
    for (int i = ogog_pkg::REG_FORWARD_X; i <= ogog_pkg::REG_FORWARD_Z; i++) begin
      if ($urandom_range(99) < 75) begin
        write_reg(ogog_pkg::CFG_IDX_W'(i), ogog_pkg::CFG_DATA_W'($urandom_range(1)));
      end
    end
    if ($urandom_range(99) < 75) begin
      write_reg(ogog_pkg::REG_AXIS_ORDER, ogog_pkg::CFG_DATA_W'($urandom_range(7)));
    end
    if ($urandom_range(99) < 5) begin
      write_reg(REG_SPARE, ogog_pkg::CFG_DATA_W'($urandom));
    end
  endtask

  task automatic test_random_walk(input int src_pct, input int snk_pct, input int n_items);
    int sent, seg;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      randomize_registers();
      seg = $urandom_range(60, 10);
      repeat (seg) send_item($urandom_range(99) < 4);
      sent += seg;
      wait_all_results();
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_entry = {m_tdata[ogog_pkg::IDX_W-1:0],
                    m_tdata[2*ogog_pkg::IDX_W-1:ogog_pkg::IDX_W], m_tlast};
      if (table_expect.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result index %0d offset %0d last %0b", $realtime,
                   seen_entry.tab_index, seen_entry.tab_offset, seen_entry.tab_last);
        end
      end else begin
        want_entry = table_expect.pop_front();
        if (seen_entry !== want_entry) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch index %0d/%0d offset %0d/%0d last %0b/%0b (exp/got)",
                     $realtime, want_entry.tab_index, seen_entry.tab_index,
                     want_entry.tab_offset, seen_entry.tab_offset,
                     want_entry.tab_last, seen_entry.tab_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ext_reg[0] = 7'd1;
    ext_reg[1] = 7'd1;
    ext_reg[2] = 7'd1;
    fwd_reg[0] = 1'b1;
    fwd_reg[1] = 1'b1;
    fwd_reg[2] = 1'b1;
    order_reg  = ogog_pkg::ORDER_012;
    walk_x = 0;
    walk_y = 0;
    walk_z = 0;
    src_idle_pct = 29;
    snk_idle_pct = 47;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_extreme_shapes();
    test_axis_orders();
    test_shrunk_extents();
    test_backpressure();
    test_random_walk(29, 47, 615);
    test_random_walk(47, 29, 615);
    test_random_walk(0, 0, 615);

    wait_all_results();
    repeat (PIPE_LATENCY + 6) @(negedge clk);
    if (fail_count == 0 && table_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ogog_pkg.sv
hw/rtl/ogog_cfg.sv
hw/rtl/ogog_walk.sv
hw/rtl/ogog_offset.sv
hw/rtl/oriented_grid_offset_generator.sv
hw/rtl/ogog_checker.sv
tb/sv/tb_top.sv
